// ----- src/rhed_pkg.sv -----
// Shared constants and types for the request header end detector.
`default_nettype none

package rhed_pkg;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned COUNT_W = 16;

    typedef logic [DATA_W-1:0]  t_byte;
    typedef logic [COUNT_W-1:0] t_count;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_BUSY     = 2'd0,
        STATUS_DONE     = 2'd1,
        STATUS_NUL_ERR  = 2'd2,
        STATUS_OVERFLOW = 2'd3
    } t_status;

    localparam t_count LIMIT_RESET = 16'd4096;

    localparam t_byte CHAR_NUL = 8'h00;
    localparam t_byte CHAR_TAB = 8'h09;
    localparam t_byte CHAR_LF  = 8'h0A;
    localparam t_byte CHAR_CR  = 8'h0D;
    localparam t_byte CHAR_SP  = 8'h20;

endpackage

`default_nettype wire

// ----- src/rhed_if.sv -----
// Channel interfaces: request byte in, result out, header limit write.
`default_nettype none

interface rhed_byte_if
    import rhed_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface rhed_result_if
    import rhed_pkg::*;
;
    logic    valid;
    logic    ready;
    t_status status;
    logic    simple_request;
    t_count  header_bytes;

    modport source (output valid, output status, output simple_request,
                    output header_bytes, input ready);
    modport sink   (input valid, input status, input simple_request,
                    input header_bytes, output ready);
endinterface

interface rhed_cfg_if
    import rhed_pkg::*;
;
    logic   valid;
    logic   ready;
    t_count header_limit;

    modport source (output valid, output header_limit, input ready);
    modport sink   (input valid, input header_limit, output ready);
endinterface

`default_nettype wire

// ----- src/request_header_end_detector.sv -----
// Top level: byte-wise HTTP request header end detector.
`default_nettype none

// Takes the received request stream one byte per request on i_req and returns
// one result per byte on o_res: in progress, header complete, NUL byte error or
// buffer overflow, together with the simple-request flag and the number of
// bytes held for the current request. Throughput is one byte per clock while the
// result is not stalled by o_res.ready; each byte passes the input register, then
// the parse state update feeding the result register. The parse state, flag and
// byte count live next to the result register, so each byte sees the state left
// by the byte before it. After a completion or an error the parse state, flag
// and count are back at their reset values and the next byte starts a new
// request. The header limit register (reset 4096) is written through i_cfg,
// which is always ready; write it only while no byte is in flight.
module request_header_end_detector
    import rhed_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    rhed_byte_if.sink             i_req,
    rhed_result_if.source         o_res,
    rhed_cfg_if.sink              i_cfg
);

    // Parser states. A blank line ends the header; a request line without a version field ends at its LF.
    typedef enum logic [2:0] {
        ST_METHOD = 3'd0,
        ST_GAP1   = 3'd1,
        ST_URI    = 3'd2,
        ST_GAP2   = 3'd3,
        ST_HDR    = 3'd4,
        ST_CR     = 3'd5,
        ST_LF     = 3'd6,
        ST_LFCR   = 3'd7
    } t_state;

    // Input stage
    logic    r_in_vld;
    t_byte   r_data;

    // Parser state
    t_state  r_state;
    logic    r_simple;
    t_count  r_count;
    t_count  r_limit;

    // Result stage
    logic    r_out_vld;
    t_status r_status;
    logic    r_out_simple;
    t_count  r_out_bytes;

    // Next values
    t_state  n_state;
    logic    n_simple;
    logic    n_done;
    t_count  n_count;

    logic    advance;
    logic    is_ws;
    logic    is_lf;
    logic    is_cr;
    logic    overflow;
    logic    nul;

    // Input byte moves into the result stage when the result slot is free
    // or being drained this cycle.
    assign advance     = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_req.ready = !r_in_vld || advance;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid          = r_out_vld;
    assign o_res.status         = r_status;
    assign o_res.simple_request = r_out_simple;
    assign o_res.header_bytes   = r_out_bytes;

    assign is_cr    = (r_data == CHAR_CR);
    assign is_lf    = (r_data == CHAR_LF);
    assign is_ws    = (r_data == CHAR_SP) || (r_data == CHAR_TAB) || is_cr;
    assign overflow = (r_count >= r_limit);
    assign nul      = (r_data == CHAR_NUL);
    assign n_count  = r_count + t_count'(1);

    // Transition for the byte in the input register.
    always_comb begin
        n_state  = r_state;
        n_simple = r_simple;
        n_done   = 1'b0;
        case (r_state)
            ST_METHOD: begin
                n_state = is_ws ? ST_GAP1 : ST_METHOD;
            end
            ST_GAP1: begin
                n_state = is_lf ? ST_METHOD : (is_ws ? ST_GAP1 : ST_URI);
            end
            ST_URI: begin
                n_done  = is_lf;
                n_state = is_ws ? ST_GAP2 : ST_URI;
            end
            ST_GAP2: begin
                // version field present: not a simple request
                n_done = is_lf;
                if (!is_lf && !is_ws) begin
                    n_simple = 1'b0;
                    n_state  = ST_HDR;
                end
            end
            ST_HDR: begin
                n_state = is_cr ? ST_CR : (is_lf ? ST_LF : ST_HDR);
            end
            ST_CR: begin
                n_state = is_lf ? ST_LF : (is_cr ? ST_CR : ST_HDR);
            end
            ST_LF: begin
                n_done  = is_lf;
                n_state = is_cr ? ST_LFCR : ST_HDR;
            end
            ST_LFCR: begin
                n_done  = is_lf;
                n_state = is_cr ? ST_LFCR : ST_HDR;
            end
            default: begin
                n_state = ST_METHOD;
            end
        endcase
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
        if (i_req.valid && i_req.ready) begin
            r_data <= i_req.data_byte;
        end
    end

    // Header limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg.valid) begin
            r_limit <= i_cfg.header_limit;
        end
    end

    // Parser state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_METHOD;
            r_simple  <= 1'b1;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                if (overflow || nul) begin
                    // errors report the state held before this byte
                    r_status     <= overflow ? STATUS_OVERFLOW : STATUS_NUL_ERR;
                    r_out_simple <= r_simple;
                    r_out_bytes  <= r_count;
                    r_state      <= ST_METHOD;
                    r_simple     <= 1'b1;
                    r_count      <= '0;
                end else begin
                    r_status     <= n_done ? STATUS_DONE : STATUS_BUSY;
                    r_out_simple <= n_simple;
                    r_out_bytes  <= n_count;
                    if (n_done) begin
                        r_state  <= ST_METHOD;
                        r_simple <= 1'b1;
                        r_count  <= '0;
                    end else begin
                        r_state  <= n_state;
                        r_simple <= n_simple;
                        r_count  <= n_count;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/rhed_checker.sv -----
// Port-level checks for the request header end detector, bound to the top.
`default_nettype none

module rhed_checker
    import rhed_pkg::*;
(
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         i_in_valid,
    input wire         i_in_ready,
    input wire         i_out_valid,
    input wire         i_out_ready,
    input wire [1:0]   i_status,
    input wire         i_simple,
    input wire [15:0]  i_bytes
);

    // stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_status) && $stable(i_simple) && $stable(i_bytes))
        else $error("result changed while stalled");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a fresh result needs a byte accepted earlier on the input
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result without an accepted byte");

    // progress and completion always count the current byte
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == STATUS_BUSY || i_status == STATUS_DONE)
            |-> i_bytes != 16'd0)
        else $error("zero byte count on a good result");

endmodule

bind request_header_end_detector rhed_checker u_rhed_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_simple    (o_res.simple_request),
    .i_bytes     (o_res.header_bytes)
);

`default_nettype wire
